>>> rtl/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg - shared types and constants for the rail fence transposer
// Beat payloads, register map codes and state encodings.
// ----------------------------------------------------------------------------
package rft_pkg;

    localparam int BYTE_W   = 8;
    localparam int LETTER_W = 7;
    localparam int RAIL_W   = 7;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Rails outside this window are clamped to it.
    localparam logic [RAIL_W-1:0] RAIL_MIN = 7'd2;
    localparam logic [RAIL_W-1:0] RAIL_MAX = 7'd64;
    localparam logic [RAIL_W-1:0] RAIL_RST = 7'd2;

    localparam logic [BYTE_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LO_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_BIT  = 8'h20;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                out_last;
        logic                overflow;
    } t_out;

    // Register index, taken from paddr[2].
    typedef enum logic [0:0] {
        REG_RAIL_COUNT   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_WALK,
        ST_RD_ORD,
        ST_RD_LET,
        ST_FILL,
        ST_SEND
    } t_top_state;

    typedef enum logic [0:0] {
        WALK_IDLE,
        WALK_RUN
    } t_walk_state;

endpackage

>>> rtl/rail_fence_transposer.sv
// ----------------------------------------------------------------------------
// rail_fence_transposer - rail fence cipher over a byte stream
// Buffers the letters of one message, then emits them in rail fence order
// (encrypt) or scattered back from their zigzag positions (decrypt).
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | sink      | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out      | source    | o_out_valid / i_out_stall | o_out_data (t_out)
//  config   | sink      | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  Message bytes are taken one beat per cycle while loading.
//  A final beat with n stored letters starts the zigzag walk on the shared
//  step unit; the order table and letter buffer are then read back one
//  output beat at a time, each through two registered RAM reads in series
//  and held while the output stalls. After a final beat with letters stored,
//  no input beat is taken until the last letter leaves.
//  Reset clears the control state and configuration registers; the RAMs need no clearing.
// ----------------------------------------------------------------------------
module rail_fence_transposer #(
    parameter int MAX_LEN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input beats
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rft_pkg::t_in                i_in_data,
    // output beats
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rft_pkg::t_out               o_out_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rft_pkg::ADDR_W-1:0]  paddr,
    input  logic [rft_pkg::DATA_W-1:0]  pwdata,
    output logic [rft_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import rft_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RAIL_W-1:0] r_rail;
    logic              r_decrypt;
    logic              cfg_wr;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail    <= RAIL_RST;
            r_decrypt <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RAIL_COUNT:   r_rail    <= pwdata[RAIL_W-1:0];
                REG_DECRYPT_MODE: r_decrypt <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RAIL_COUNT:   prdata = DATA_W'(r_rail);
            REG_DECRYPT_MODE: prdata = DATA_W'(r_decrypt);
            default:          prdata = '0;
        endcase
    end

    // Clamp the rail count into the legal window.
    logic [RAIL_W-1:0] rails_eff;
    always_comb begin
        if (r_rail < RAIL_MIN) begin
            rails_eff = RAIL_MIN;
        end else if (r_rail > RAIL_MAX) begin
            rails_eff = RAIL_MAX;
        end else begin
            rails_eff = r_rail;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    t_top_state       r_state,     n_state;
    logic [CNT_W-1:0] r_count,     n_count;
    logic             r_ovf,       n_ovf;
    logic [CNT_W-1:0] r_k,         n_k;
    logic             r_out_valid, n_out_valid;
    t_out             r_out,       n_out;

    logic                in_acc;
    logic                is_upper;
    logic                is_letter;
    logic [BYTE_W-1:0]   lower_byte;
    logic                let_we;
    logic                walk_start;
    logic                walk_done;
    logic                ord_we;
    logic [IDX_W-1:0]    ord_waddr;
    logic [IDX_W-1:0]    ord_wdata;
    logic [IDX_W-1:0]    ord_rdata;
    logic [LETTER_W-1:0] let_rdata;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Letter filter: fold upper case down, drop everything else.
    always_comb begin
        is_upper   = (i_in_data.in_byte >= CHAR_UP_A) && (i_in_data.in_byte <= CHAR_UP_Z);
        is_letter  = is_upper ||
                     ((i_in_data.in_byte >= CHAR_LO_A) && (i_in_data.in_byte <= CHAR_LO_Z));
        lower_byte = is_upper ? (i_in_data.in_byte | CASE_BIT) : i_in_data.in_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        let_we      = 1'b0;
        walk_start  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (is_letter) begin
                        if (r_count < CNT_W'(MAX_LEN)) begin
                            let_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_in_data.in_last) begin
                        if (n_count == '0) begin
                            // empty message: nothing to send, just clear
                            n_ovf = 1'b0;
                        end else begin
                            walk_start = 1'b1;
                            n_state    = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_k     = '0;
                    n_state = ST_RD_ORD;
                end
            end
            ST_RD_ORD: n_state = ST_RD_LET;
            ST_RD_LET: n_state = ST_FILL;
            ST_FILL: begin
                n_out.out_letter = let_rdata;
                n_out.out_last   = (r_k + CNT_W'(1)) == r_count;
                n_out.overflow   = r_ovf;
                n_out_valid      = 1'b1;
                n_state          = ST_SEND;
            end
            ST_SEND: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out.out_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = ST_RD_ORD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: walk sequencer, order table, letter buffer
    // ------------------------------------------------------------------
    rft_zigzag #(
        .MAX_LEN (MAX_LEN)
    ) u_zigzag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (walk_start),
        .i_count   (r_count),
        .i_rails   (rails_eff),
        .i_decrypt (r_decrypt),
        .o_wr_en   (ord_we),
        .o_wr_addr (ord_waddr),
        .o_wr_data (ord_wdata),
        .o_done    (walk_done)
    );

    // Order table: read at the output index.
    rft_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_LEN)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (ord_rdata)
    );

    // Letter buffer: written in arrival order, read where the table points.
    rft_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (MAX_LEN)
    ) u_letter_ram (
        .i_clk   (i_clk),
        .i_we    (let_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (lower_byte[LETTER_W-1:0]),
        .i_raddr (ord_rdata),
        .o_rdata (let_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("letter count beyond buffer depth");

    a_no_out_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !o_out_valid)
        else $error("output beat while loading");

    a_last_letter_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.in_last && is_letter) |=> (r_state == ST_WALK))
        else $error("final letter did not start the walk");

    a_run_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.out_last)
            |=> (r_count == '0 && !r_ovf && r_state == ST_LOAD))
        else $error("message state not cleared after final beat");

endmodule

>>> rtl/rft_ram.sv
// ----------------------------------------------------------------------------
// rft_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rft_zigzag.sv
// ----------------------------------------------------------------------------
// rft_zigzag - zigzag walk sequencer
// Steps row by row along the rail pattern with one shared step unit and writes
// one entry of the order table per visited position.
// ----------------------------------------------------------------------------
module rft_zigzag #(
    parameter int MAX_LEN = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0]      i_count,
    input  logic [rft_pkg::RAIL_W-1:0]        i_rails,
    input  logic                              i_decrypt,
    output logic                              o_wr_en,
    output logic [$clog2(MAX_LEN)-1:0]        o_wr_addr,
    output logic [$clog2(MAX_LEN)-1:0]        o_wr_data,
    output logic                              o_done
);

    import rft_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int POS_W  = $clog2(MAX_LEN + 2 * int'(RAIL_MAX));
    localparam int STEP_W = RAIL_W + 1;

    t_walk_state       r_state, n_state;
    logic [RAIL_W-1:0] r_row,   n_row;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic              r_down,  n_down;
    logic [CNT_W-1:0]  r_k,     n_k;

    logic [RAIL_W-1:0] rails_m1;
    logic [RAIL_W-1:0] half_step;
    logic [STEP_W-1:0] step;
    logic [CNT_W-1:0]  k_inc;
    logic              in_range;

    // Shared step unit: distance to the next position on this rail.
    always_comb begin
        rails_m1 = i_rails - RAIL_W'(1);
        if (r_row == '0 || r_row == rails_m1) begin
            half_step = rails_m1;
        end else if (r_down) begin
            half_step = rails_m1 - r_row;
        end else begin
            half_step = r_row;
        end
        step     = {half_step, 1'b0};
        k_inc    = r_k + CNT_W'(1);
        in_range = r_pos < POS_W'(i_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WALK_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_row  <= n_row;
        r_pos  <= n_pos;
        r_down <= n_down;
        r_k    <= n_k;
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_pos     = r_pos;
        n_down    = r_down;
        n_k       = r_k;
        o_wr_en   = 1'b0;
        o_done    = 1'b0;
        o_wr_addr = i_decrypt ? r_pos[IDX_W-1:0] : r_k[IDX_W-1:0];
        o_wr_data = i_decrypt ? r_k[IDX_W-1:0]   : r_pos[IDX_W-1:0];
        unique case (r_state)
            WALK_IDLE: begin
                if (i_start) begin
                    n_state = WALK_RUN;
                    n_row   = '0;
                    n_pos   = '0;
                    n_down  = 1'b1;
                    n_k     = '0;
                end
            end
            WALK_RUN: begin
                if (in_range) begin
                    o_wr_en = 1'b1;
                    n_k     = k_inc;
                    n_pos   = r_pos + POS_W'(step);
                    n_down  = !r_down;
                    if (k_inc == i_count) begin
                        o_done  = 1'b1;
                        n_state = WALK_IDLE;
                    end
                end else begin
                    // Rail exhausted: drop to the next one.
                    n_row  = r_row + RAIL_W'(1);
                    n_pos  = POS_W'(r_row + RAIL_W'(1));
                    n_down = 1'b1;
                end
            end
            default: n_state = WALK_IDLE;
        endcase
    end

endmodule

>>> tb/rail_fence_transposer_test.sv
// ----------------------------------------------------------------------------
// rail_fence_transposer_test - self-checking bench for the rail fence transposer
// Streams directed and random messages through the block at several rail
// counts, in both modes. A scoreboard predicts every output letter and
// checks the letters in order.
// ----------------------------------------------------------------------------
module rail_fence_transposer_test;
    import rft_pkg::*;

    localparam int MSG_CAP     = 64;       // letter buffer depth of the block
    localparam int CYCLE_LIMIT = 2000000;  // far above the slowest legal run
    localparam int SETTLE      = 300;      // idle margin after the last owed letter
    localparam int ITEM_BUDGET = 500;      // input beats across the random slices
    localparam int CROSS_RUN   = 20;       // mean overrun of the message crossing a mark

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the message buffer and registers, and queues the
    // letters that each final beat must produce.
    // ------------------------------------------------------------------------
    class fence_ledger;
        logic [RAIL_W-1:0] rails_reg;
        logic              decrypt_reg;
        logic [7:0]        held_letters[$];
        bit                dropped;
        t_out              owed_letters[$];
        int                errors;

        function new();
            rails_reg   = RAIL_RST;
            decrypt_reg = 1'b0;
            dropped     = 1'b0;
            errors      = 0;
        endfunction

        static function bit is_letter(logic [7:0] b);
            return (b >= CHAR_UP_A && b <= CHAR_UP_Z) || (b >= CHAR_LO_A && b <= CHAR_LO_Z);
        endfunction

        // Walk the zigzag rail by rail and queue the transposed letters.
        function void queue_transposed();
            int   n, rails, k, row, pos;
            bit   down;
            int   walk[MSG_CAP];
            int   order[MSG_CAP];
            logic [7:0] ch;
            t_out beat;
            n     = held_letters.size();
            rails = int'(rails_reg);
            if (rails < int'(RAIL_MIN)) rails = int'(RAIL_MIN);
            if (rails > int'(RAIL_MAX)) rails = int'(RAIL_MAX);
            k = 0;
            for (row = 0; row < rails; row++) begin
                pos  = row;
                down = 1'b1;
                while (pos < n && k < n) begin
                    walk[k] = pos;
                    k++;
                    if (row == 0 || row == rails - 1) begin
                        pos += 2 * (rails - 1);
                    end else begin
                        pos += down ? 2 * (rails - row - 1) : 2 * row;
                        down = !down;
                    end
                end
            end
            for (k = 0; k < n; k++) begin
                if (decrypt_reg) order[walk[k]] = k;
                else             order[k] = walk[k];
            end
            for (k = 0; k < n; k++) begin
                ch              = held_letters[order[k]];
                beat.out_letter = ch[LETTER_W-1:0];
                beat.out_last   = (k == n - 1);
                beat.overflow   = dropped;
                owed_letters.push_back(beat);
            end
            held_letters.delete();
            dropped = 1'b0;
        endfunction

        function void take_byte(t_in item);
            logic [7:0] b;
            b = item.in_byte;
            if (is_letter(b)) begin
                b = b | CASE_BIT;
                if (held_letters.size() < MSG_CAP) held_letters.push_back(b);
                else                               dropped = 1'b1;
            end
            if (item.in_last) queue_transposed();
        endfunction

        function void match_letter(t_out got);
            t_out want;
            if (owed_letters.size() == 0) begin
                errors++;
                $display("%0t: letter beat with nothing owed, actual %h/%b/%b", $time,
                         got.out_letter, got.out_last, got.overflow);
                return;
            end
            want = owed_letters.pop_front();
            if (got.out_letter !== want.out_letter) begin
                errors++;
                $display("%0t: out_letter mismatch, expected %h actual %h", $time,
                         want.out_letter, got.out_letter);
            end
            if (got.out_last !== want.out_last) begin
                errors++;
                $display("%0t: out_last mismatch, expected %b actual %b", $time,
                         want.out_last, got.out_last);
            end
            if (got.overflow !== want.overflow) begin
                errors++;
                $display("%0t: overflow mismatch, expected %b actual %b", $time,
                         want.overflow, got.overflow);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block connections, all inputs known from time zero.
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    fence_ledger ledger;

    int src_idle_pct  = 19;   // chance the sender skips a cycle
    int sink_idle_pct = 63;   // chance the receiver stalls a cycle
    int hold_left     = 0;    // long receiver hold-off, counted down below
    int kept_items    = 0;    // input beats taken by the block
    int unsigned cycles = 0;

    rail_fence_transposer #(
        .MAX_LEN(MSG_CAP)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a run that hangs; no legal run comes anywhere near this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** rail_fence_transposer: FAILED **");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request so
    // the block backs up and stalls its input side.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Sample both channels at the rising edge; inputs only move on the
    // falling edge, so the values seen here are the ones the block took.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) ledger.take_byte(i_in_data);
            if (o_out_valid && !i_out_stall) ledger.match_letter(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one beat, with random gaps ahead of it, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_data.in_byte <= b;
        i_in_data.in_last <= last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        kept_items++;
    endtask

    // Send a text, marking its final character as the end when asked.
    task automatic send_word(input string s, input bit close);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
    endtask

    // Send a random message; letters are drawn in both cases, other bytes are
    // drawn from everything that is not a letter.
    task automatic send_message(input int n_bytes, input int letter_pct);
        logic [7:0] b;
        int         i;
        for (i = 0; i < n_bytes; i++) begin
            if ($urandom_range(99) < letter_pct) begin
                b = CHAR_LO_A + 8'($urandom_range(25));
                if ($urandom_range(1)) b = b & ~CASE_BIT;
            end else begin
                do b = 8'($urandom_range(255)); while (fence_ledger::is_letter(b));
            end
            send_byte(b, i == n_bytes - 1);
        end
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RAIL_COUNT) ledger.rails_reg = value[RAIL_W-1:0];
        else                       ledger.decrypt_reg = value[0];
    endtask

    task automatic set_fence(input int rails, input bit decrypt);
        write_reg(REG_RAIL_COUNT, DATA_W'(rails));
        write_reg(REG_DECRYPT_MODE, DATA_W'(decrypt));
    endtask

    // Drop valid, wait for every owed letter, then idle for SETTLE more
    // falling edges before anything else happens.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (ledger.owed_letters.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int rail_plan[6];
        bit mode_plan[6];
        int phase, part, target, pick;

        ledger = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: letter range edges against their non-letter neighbors,
        // all-zero and all-one bytes, an empty message, a lone letter.
        set_fence(3, 1'b0);
        send_word("A@Z[a", 1'b0);
        send_byte(8'h60, 1'b0);
        send_word("z{", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h20, 1'b1);
        send_word("Q", 1'b1);
        settle_block();

        // Directed: rail count below two falls back to two, in decrypt mode.
        set_fence(0, 1'b1);
        send_word("rAiLfEnCe", 1'b1);

        // Settings per random slice: clamped low and high rail counts, the
        // true extremes, one random count, in both modes.
        rail_plan = '{2, 127, 1, 64, 0, 0};
        mode_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        rail_plan[4] = $urandom_range(3, 63);
        mode_plan[4] = $urandom_range(1);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 19;
                    sink_idle_pct = 63;
                end
                1: begin
                    src_idle_pct  = 63;
                    sink_idle_pct = 19;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (part = 0; part < 2; part++) begin
                settle_block();
                set_fence(rail_plan[2 * phase + part], mode_plan[2 * phase + part]);
                // Hold the receiver off while the sender keeps offering, so the
                // block fills and stalls its input.
                if (phase == 0 && part == 0) hold_left = 600;
                // The message that crosses the mark runs past it, so aim short.
                target = kept_items + ITEM_BUDGET / 6 - CROSS_RUN;
                while (kept_items < target) begin
                    pick = $urandom_range(99);
                    if (pick < 6)       send_message($urandom_range(1, 4), 0);
                    else if (pick < 14) send_message($urandom_range(66, 80), 97);
                    else if (pick < 30) send_message($urandom_range(20, 64), 85);
                    else                send_message($urandom_range(1, 16), 80);
                end
            end
        end

        settle_block();
        if (ledger.errors == 0 && ledger.owed_letters.size() == 0) begin
            $display("** rail_fence_transposer: PASSED **");
        end else begin
            $display("** rail_fence_transposer: FAILED **");
        end
        $finish;
    end

endmodule
